// ===== src/kmpoc_pkg.sv =====
`default_nettype none

package kmpoc_pkg;

	localparam int CMD_W           = 2;
	localparam int SYM_W           = 8;
	localparam int MAX_PATTERN_DEF = 64;
	localparam int COUNT_BITS_DEF  = 16;
	localparam int BORDER_W_DEF    = $clog2(MAX_PATTERN_DEF + 1);

	typedef enum logic [CMD_W-1:0] {
		CMD_RESTART = 2'd0,
		CMD_PATTERN = 2'd1,
		CMD_TEXT    = 2'd2
	} cmd_t;

endpackage

`default_nettype wire

// ===== src/kmpoc_in_if.sv =====
`default_nettype none

interface kmpoc_in_if;
	import kmpoc_pkg::*;

	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] cmd;
	logic [SYM_W-1:0] symbol;

	modport source (output valid, output cmd, output symbol, input ready);
	modport sink (input valid, input cmd, input symbol, output ready);
endinterface

`default_nettype wire

// ===== src/kmpoc_out_if.sv =====
`default_nettype none

interface kmpoc_out_if #(
	parameter int BORDER_W = kmpoc_pkg::BORDER_W_DEF,
	parameter int COUNT_W  = kmpoc_pkg::COUNT_BITS_DEF
);
	logic                valid;
	logic                ready;
	logic                matched;
	logic [COUNT_W-1:0]  match_count;
	logic                unique_res;
	logic [BORDER_W-1:0] border_length;
	logic                overflow;

	modport source (
		output valid, output matched, output match_count, output unique_res,
		output border_length, output overflow, input ready
	);
	modport sink (
		input valid, input matched, input match_count, input unique_res,
		input border_length, input overflow, output ready
	);
endinterface

`default_nettype wire

// ===== src/kmp_occurrence_counter.sv =====
// Online prefix-function matcher. Words arrive on req (cmd, symbol): restart,
// append a pattern symbol, or feed a text symbol. Every accepted word yields
// exactly one result word on res: matched, saturating match_count,
// unique_res, border_length and overflow.
// The block takes one word at a time; req.ready is high only while idle.
// A restart, a dropped or ignored pattern symbol, the first pattern symbol,
// a text symbol against an empty pattern and an unknown command go straight
// to the finish state, which loads the result register. Other pattern and
// text symbols walk the failure links through the symbol and link
// memories, one link per cycle, then go to the finish state; a text symbol
// whose border equals the whole pattern first passes a fix state. req.ready
// returns as the result loads.
// The walk amortises to under two link steps per symbol.
// Reset clears length, border, text flag and count; the memories are not
// cleared, only written entries are used.
// The result sits in an output register; while res.ready is low the block
// may accept and work on the next word, and holds its finished result
// until the register frees.
`default_nettype none

module kmp_occurrence_counter #(
	parameter int MAX_PATTERN = kmpoc_pkg::MAX_PATTERN_DEF,
	parameter int COUNT_BITS  = kmpoc_pkg::COUNT_BITS_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	kmpoc_in_if.sink    req,
	kmpoc_out_if.source res
);
	import kmpoc_pkg::*;

	localparam int BW = $clog2(MAX_PATTERN + 1);
	localparam int AW = $clog2(MAX_PATTERN);
	localparam logic [BW-1:0] PLEN_MAX = BW'(MAX_PATTERN);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FIX,
		ST_WALK,
		ST_FIN
	} state_t;

	state_t                state_q;
	logic [BW-1:0]         plen_q;
	logic [BW-1:0]         border_q;
	logic                  in_text_q;
	logic [COUNT_BITS-1:0] occ_q;
	logic                  matched_q;
	logic                  ovf_q;
	logic [SYM_W-1:0]      sym_q;
	logic [BW-1:0]         j_q;

	logic                  oval_q;
	logic                  omatched_q;
	logic [COUNT_BITS-1:0] ocount_q;
	logic                  ounique_q;
	logic [BW-1:0]         oborder_q;
	logic                  oovf_q;

	logic [SYM_W-1:0] sym_mem [MAX_PATTERN];
	logic [BW-1:0]    lnk_mem [MAX_PATTERN];
	logic [SYM_W-1:0] sym_rd_q;
	logic [BW-1:0]    lnk_rd_q;

	logic             fix;
	logic             fix_rd;
	logic [BW-1:0]    j_rd;
	logic [BW-1:0]    j_m1;
	logic [BW-1:0]    plen_m1;
	logic             step;
	logic             hit;
	logic [BW-1:0]    j_fin;
	logic             accept;
	logic             slot_free;
	logic             wr_en;
	logic [SYM_W-1:0] wr_sym;
	logic [BW-1:0]    wr_lnk;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign slot_free = !oval_q || res.ready;

	assign fix     = in_text_q && (border_q == plen_q);
	assign hit     = (sym_rd_q == sym_q);
	assign step    = (j_q != '0) && !hit;
	assign j_fin   = j_q + BW'(hit);
	assign plen_m1 = plen_q - BW'(1);
	assign j_m1    = j_rd - BW'(1);

	always_comb begin
		fix_rd = 1'b0;
		j_rd   = lnk_rd_q;
		if (state_q == ST_IDLE) begin
			fix_rd = fix;
			if (req.cmd == CMD_TEXT && !in_text_q) begin
				j_rd = '0;
			end else begin
				j_rd = border_q;
			end
		end
	end

	always_comb begin
		wr_en  = 1'b0;
		wr_sym = sym_q;
		wr_lnk = j_fin;
		if (state_q == ST_IDLE) begin
			wr_en  = accept && req.cmd == CMD_PATTERN && !in_text_q && plen_q == '0;
			wr_sym = req.symbol;
			wr_lnk = '0;
		end else if (state_q == ST_WALK) begin
			wr_en = !step && !in_text_q;
		end
	end

	// symbol and failure-link memories, registered reads
	always_ff @(posedge clk) begin
		if (wr_en) begin
			sym_mem[plen_q[AW-1:0]] <= wr_sym;
			lnk_mem[plen_q[AW-1:0]] <= wr_lnk;
		end
		sym_rd_q <= sym_mem[j_rd[AW-1:0]];
		lnk_rd_q <= lnk_mem[fix_rd ? plen_m1[AW-1:0] : j_m1[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			plen_q     <= '0;
			border_q   <= '0;
			in_text_q  <= 1'b0;
			occ_q      <= '0;
			matched_q  <= 1'b0;
			ovf_q      <= 1'b0;
			sym_q      <= '0;
			j_q        <= '0;
			oval_q     <= 1'b0;
			omatched_q <= 1'b0;
			ocount_q   <= '0;
			ounique_q  <= 1'b0;
			oborder_q  <= '0;
			oovf_q     <= 1'b0;
		end else begin
			if (res.ready && state_q != ST_FIN) begin
				oval_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						matched_q <= 1'b0;
						sym_q     <= req.symbol;
						j_q       <= j_rd;
						case (req.cmd)
							CMD_RESTART: begin
								plen_q    <= '0;
								border_q  <= '0;
								in_text_q <= 1'b0;
								occ_q     <= '0;
								ovf_q     <= 1'b0;
								state_q   <= ST_FIN;
							end
							CMD_PATTERN: begin
								ovf_q <= !in_text_q && plen_q == PLEN_MAX;
								if (in_text_q || plen_q == PLEN_MAX) begin
									state_q <= ST_FIN;
								end else if (plen_q == '0) begin
									plen_q   <= BW'(1);
									border_q <= '0;
									state_q  <= ST_FIN;
								end else begin
									state_q <= ST_WALK;
								end
							end
							CMD_TEXT: begin
								ovf_q     <= 1'b0;
								in_text_q <= 1'b1;
								if (plen_q == '0) begin
									border_q <= '0;
									state_q  <= ST_FIN;
								end else if (fix) begin
									state_q <= ST_FIX;
								end else begin
									state_q <= ST_WALK;
								end
							end
							default: begin
								ovf_q   <= 1'b0;
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_FIX: begin
					j_q     <= j_rd;
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (step) begin
						j_q <= j_rd;
					end else begin
						border_q <= j_fin;
						state_q  <= ST_FIN;
						if (!in_text_q) begin
							plen_q <= plen_q + BW'(1);
						end else if (j_fin == plen_q) begin
							matched_q <= 1'b1;
							if (occ_q != '1) begin
								occ_q <= occ_q + COUNT_BITS'(1);
							end
						end
					end
				end
				ST_FIN: begin
					if (slot_free) begin
						oval_q     <= 1'b1;
						omatched_q <= matched_q;
						ocount_q   <= occ_q;
						ounique_q  <= (occ_q == COUNT_BITS'(1));
						oborder_q  <= border_q;
						oovf_q     <= ovf_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res.valid         = oval_q;
	assign res.matched       = omatched_q;
	assign res.match_count   = ocount_q;
	assign res.unique_res    = ounique_q;
	assign res.border_length = oborder_q;
	assign res.overflow      = oovf_q;

	a_border_le_len: assert property (@(posedge clk) disable iff (!arst_n)
		border_q <= plen_q)
		else $error("border beyond pattern length");

	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> j_q < plen_q)
		else $error("walk index beyond stored pattern");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.cmd == CMD_RESTART |=> plen_q == '0 && occ_q == '0 && !in_text_q)
		else $error("restart left state behind");

	a_match_full: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.matched |-> res.border_length != '0 && res.match_count != '0)
		else $error("match without border or count");

endmodule

`default_nettype wire
